>>> design/kcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types and codes for the keypad combination lock.
// ----------------------------------------------------------------------------
package kcl_pkg;

   // command codes
   localparam logic [1:0] CMD_KEY  = 2'd0;
   localparam logic [1:0] CMD_TICK = 2'd1;
   localparam logic [1:0] CMD_PROG = 2'd2;

   // lock modes
   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_ENTRY = 3'd1;
   localparam logic [2:0] MODE_OPEN  = 3'd2;
   localparam logic [2:0] MODE_PROG  = 3'd3;
   localparam logic [2:0] MODE_ALARM = 3'd4;

   // sound codes
   localparam logic [2:0] SOUND_NONE  = 3'd0;
   localparam logic [2:0] SOUND_KEY   = 3'd1;
   localparam logic [2:0] SOUND_OPEN  = 3'd2;
   localparam logic [2:0] SOUND_WRONG = 3'd3;
   localparam logic [2:0] SOUND_SIREN = 3'd4;
   localparam logic [2:0] SOUND_LOCK  = 3'd5;
   localparam logic [2:0] SOUND_SAVED = 3'd6;

   // special keys and key range
   localparam logic [4:0] KEY_FIRST = 5'd1;
   localparam logic [4:0] KEY_LAST  = 5'd16;
   localparam logic [4:0] KEY_STAR  = 5'd13;
   localparam logic [4:0] KEY_HASH  = 5'd15;

   // configuration register indexes
   localparam logic [1:0] REG_ERROR_LIMIT   = 2'd0;
   localparam logic [1:0] REG_HOLD_TICKS    = 2'd1;
   localparam logic [1:0] REG_MASTER_CODE   = 2'd2;
   localparam logic [1:0] REG_MASTER_LENGTH = 2'd3;

   // configuration reset values
   localparam logic [3:0]  ERROR_LIMIT_RESET   = 4'd3;
   localparam logic [15:0] HOLD_TICKS_RESET    = 16'd60000;
   localparam logic [55:0] MASTER_CODE_RESET   = 56'd150462337538;
   localparam logic [3:0]  MASTER_LENGTH_RESET = 4'd10;

   // code length limits
   localparam int MIN_CODE_LEN  = 5;
   localparam int MAX_CODE_LEN  = 13;
   localparam int MASTER_DIGITS = 14;
   localparam int INIT_CODE_LEN = 10;

   localparam int CSR_DATA_W = 56;
   localparam logic [15:0] HOLD_SAT = 16'hFFFF;
   localparam logic [3:0]  MISS_SAT = 4'hF;

   typedef struct packed {
      logic [1:0] command;
      logic [4:0] key_code;
      logic       star_and_hash_held;
      logic       star_held;
      logic       vibration;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic        bolt_open;
      logic [3:0]  entered_length;
      logic [13:0] display_value;
      logic [2:0]  sound;
      logic [3:0]  wrong_count;
   } rsp_payload_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } key_digit_type;

   // keypad position to decimal digit
   function automatic key_digit_type key_to_digit(input logic [4:0] key);
      key_digit_type d;
      d.valid = 1'b1;
      case (key)
         5'd1:    d.value = 4'd1;
         5'd2:    d.value = 4'd2;
         5'd3:    d.value = 4'd3;
         5'd5:    d.value = 4'd4;
         5'd6:    d.value = 4'd5;
         5'd7:    d.value = 4'd6;
         5'd9:    d.value = 4'd7;
         5'd10:   d.value = 4'd8;
         5'd11:   d.value = 4'd9;
         5'd14:   d.value = 4'd0;
         default: begin
            d.valid = 1'b0;
            d.value = 4'd0;
         end
      endcase
      return d;
   endfunction

   // factory code 1 2 3 4 5 6 7 8 9 0, zero beyond
   function automatic logic [3:0] init_digit(input int idx);
      logic [3:0] v;
      v = 4'd0;
      if (idx < INIT_CODE_LEN - 1) begin
         v = 4'(idx + 1);
      end
      return v;
   endfunction

endpackage
`default_nettype wire

>>> design/kcl_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcl_in_stage
// Input register for request beats, with stall toward the sender.
// ----------------------------------------------------------------------------
module kcl_in_stage
   import kcl_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_data,
   input  wire logic            advance,
   output logic                 item_valid,
   output req_payload_type      item_data
);

   logic            valid_ff;
   logic            valid_in;
   req_payload_type data_ff;
   logic            load;

   // accept a new beat when empty or whenever the held one moves on
   assign req_stall = valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule
`default_nettype wire

>>> design/kcl_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcl_core
// Lock state, configuration registers and the combinational step logic.
// ----------------------------------------------------------------------------
module kcl_core
   import kcl_pkg::*;
#(
   parameter int MAX_DIGITS = 14
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  step,
   input  wire req_payload_type       item,
   output rsp_payload_type            result
);

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);

   // configuration
   logic [3:0]  error_limit_ff;
   logic [15:0] hold_ticks_ff;
   logic [55:0] master_code_ff;
   logic [3:0]  master_length_ff;

   // lock state
   logic [2:0]       mode_ff, mode_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] stored_cnt_ff, stored_cnt_in;
   logic [3:0]       miss_ff, miss_in;
   logic [15:0]      lock_hold_ff, lock_hold_in;
   logic [15:0]      dual_hold_ff, dual_hold_in;
   logic             dual_ready_ff, dual_ready_in;
   logic             master_entry_ff, master_entry_in;
   logic [3:0][3:0]  shown_ff, shown_in;
   logic [3:0]       entry_ff  [MAX_DIGITS];
   logic [3:0]       stored_ff [MAX_DIGITS];

   // step logic
   key_digit_type        dig;
   logic                 key_ok;
   logic                 len_ok;
   logic                 push;
   logic                 copy;
   logic [2:0]           sound_in;
   logic [3:0]           miss_sat;
   logic                 vib_alarm;
   logic [2:0]           tick_mode;
   logic [15:0]          dual_base;
   logic                 ready_base;
   logic                 entry_base;
   logic [MAX_DIGITS-1:0] stored_eq;
   logic [MAX_DIGITS-1:0] master_eq;
   logic                 stored_match;
   logic                 master_match;
   logic [13:0]          display_bin;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         error_limit_ff   <= ERROR_LIMIT_RESET;
         hold_ticks_ff    <= HOLD_TICKS_RESET;
         master_code_ff   <= MASTER_CODE_RESET;
         master_length_ff <= MASTER_LENGTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ERROR_LIMIT:   error_limit_ff   <= csr_wdata[3:0];
            REG_HOLD_TICKS:    hold_ticks_ff    <= csr_wdata[15:0];
            REG_MASTER_CODE:   master_code_ff   <= csr_wdata[55:0];
            REG_MASTER_LENGTH: master_length_ff <= csr_wdata[3:0];
         endcase
      end
   end

   // per-digit compares against the stored and master codes
   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cmp
      assign stored_eq[i] = (CNT_W'(i) >= cnt_ff) || (entry_ff[i] == stored_ff[i]);
      if (i < MASTER_DIGITS) begin : g_master
         assign master_eq[i] = (CNT_W'(i) >= cnt_ff) ||
                               (entry_ff[i] == master_code_ff[4*i +: 4]);
      end else begin : g_beyond
         assign master_eq[i] = (CNT_W'(i) >= cnt_ff);
      end
   end

   assign stored_match = (cnt_ff == stored_cnt_ff) && (&stored_eq);
   assign master_match = (8'(cnt_ff) == 8'(master_length_ff)) &&
                         (8'(cnt_ff) <= 8'(MASTER_DIGITS)) && (&master_eq);

   assign dig    = key_to_digit(item.key_code);
   assign key_ok = (item.key_code >= KEY_FIRST) && (item.key_code <= KEY_LAST);
   assign len_ok = (cnt_ff >= CNT_W'(MIN_CODE_LEN)) && (cnt_ff <= CNT_W'(MAX_CODE_LEN));
   assign miss_sat  = (miss_ff != MISS_SAT) ? miss_ff + 4'd1 : miss_ff;
   assign vib_alarm = item.vibration && (mode_ff != MODE_ALARM);
   assign tick_mode = vib_alarm ? MODE_ALARM : mode_ff;
   assign dual_base  = vib_alarm ? 16'd0 : dual_hold_ff;
   assign ready_base = vib_alarm ? 1'b0 : dual_ready_ff;
   assign entry_base = vib_alarm ? 1'b0 : master_entry_ff;

   // next state for one item
   always_comb begin
      mode_in         = mode_ff;
      cnt_in          = cnt_ff;
      stored_cnt_in   = stored_cnt_ff;
      miss_in         = miss_ff;
      lock_hold_in    = lock_hold_ff;
      dual_hold_in    = dual_hold_ff;
      dual_ready_in   = dual_ready_ff;
      master_entry_in = master_entry_ff;
      shown_in        = shown_ff;
      sound_in        = SOUND_NONE;
      push            = 1'b0;
      copy            = 1'b0;
      unique case (item.command)
         CMD_KEY: begin
            if (key_ok) begin
               sound_in = SOUND_KEY;
               if (dig.valid) begin
                  shown_in = {shown_ff[2:0], dig.value};
               end
               case (mode_ff)
                  MODE_IDLE: begin
                     if (item.key_code == KEY_HASH) begin
                        mode_in = MODE_ENTRY;
                        cnt_in  = '0;
                     end
                  end
                  MODE_ENTRY: begin
                     if (item.key_code == KEY_STAR) begin
                        if (len_ok) begin
                           if (stored_match) begin
                              mode_in      = MODE_OPEN;
                              cnt_in       = '0;
                              miss_in      = 4'd0;
                              lock_hold_in = 16'd0;
                              sound_in     = SOUND_OPEN;
                           end else begin
                              miss_in = miss_sat;
                              cnt_in  = '0;
                              if (miss_sat >= error_limit_ff) begin
                                 mode_in         = MODE_ALARM;
                                 dual_hold_in    = 16'd0;
                                 dual_ready_in   = 1'b0;
                                 master_entry_in = 1'b0;
                                 sound_in        = SOUND_SIREN;
                              end else begin
                                 mode_in  = MODE_IDLE;
                                 sound_in = SOUND_WRONG;
                              end
                           end
                        end
                     end else begin
                        push = 1'b1;
                     end
                  end
                  MODE_PROG: begin
                     push = 1'b1;
                  end
                  MODE_ALARM: begin
                     if (master_entry_ff) begin
                        if (item.key_code == KEY_STAR) begin
                           if (cnt_ff != '0) begin
                              dual_ready_in   = 1'b0;
                              master_entry_in = 1'b0;
                              cnt_in          = '0;
                              if (master_match) begin
                                 mode_in = MODE_IDLE;
                              end else begin
                                 sound_in = SOUND_SIREN;
                              end
                           end
                        end else begin
                           push = 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         CMD_TICK: begin
            // vibration trips the alarm first
            if (vib_alarm) begin
               mode_in  = MODE_ALARM;
               cnt_in   = '0;
               sound_in = SOUND_SIREN;
            end
            dual_hold_in    = dual_base;
            dual_ready_in   = ready_base;
            master_entry_in = entry_base;
            // dual hold of star and hash in alarm
            if ((tick_mode == MODE_ALARM) && item.star_and_hash_held) begin
               if (dual_base != HOLD_SAT) begin
                  dual_hold_in = dual_base + 16'd1;
                  if (dual_base + 16'd1 == hold_ticks_ff) begin
                     dual_ready_in = 1'b1;
                  end
               end
            end else begin
               dual_hold_in = 16'd0;
            end
            if ((tick_mode == MODE_ALARM) && dual_ready_in && !entry_base) begin
               master_entry_in = 1'b1;
               cnt_in          = '0;
               shown_in        = '0;
            end
            // star hold while open locks the door
            if ((tick_mode == MODE_OPEN) && item.star_held) begin
               if (lock_hold_ff != HOLD_SAT) begin
                  if (lock_hold_ff + 16'd1 == hold_ticks_ff) begin
                     mode_in      = MODE_IDLE;
                     lock_hold_in = 16'd0;
                     sound_in     = SOUND_LOCK;
                  end else begin
                     lock_hold_in = lock_hold_ff + 16'd1;
                  end
               end
            end else begin
               lock_hold_in = 16'd0;
            end
         end
         CMD_PROG: begin
            if (mode_ff != MODE_PROG) begin
               mode_in = MODE_PROG;
               cnt_in  = '0;
            end else if (len_ok) begin
               copy          = 1'b1;
               stored_cnt_in = cnt_ff;
               cnt_in        = '0;
               mode_in       = MODE_IDLE;
               sound_in      = SOUND_SAVED;
            end
         end
         default: ;
      endcase
      // digit into the entry buffer unless full
      if (push && dig.valid && (cnt_ff < CNT_W'(MAX_DIGITS))) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else begin
         push = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_IDLE;
         cnt_ff          <= '0;
         stored_cnt_ff   <= CNT_W'(INIT_CODE_LEN);
         miss_ff         <= 4'd0;
         lock_hold_ff    <= 16'd0;
         dual_hold_ff    <= 16'd0;
         dual_ready_ff   <= 1'b0;
         master_entry_ff <= 1'b0;
         shown_ff        <= '0;
      end else if (step) begin
         mode_ff         <= mode_in;
         cnt_ff          <= cnt_in;
         stored_cnt_ff   <= stored_cnt_in;
         miss_ff         <= miss_in;
         lock_hold_ff    <= lock_hold_in;
         dual_hold_ff    <= dual_hold_in;
         dual_ready_ff   <= dual_ready_in;
         master_entry_ff <= master_entry_in;
         shown_ff        <= shown_in;
      end
   end

   // entry buffer and stored code
   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_digits
      always_ff @(posedge clock) begin
         if (step && push && (cnt_ff == CNT_W'(i))) begin
            entry_ff[i] <= dig.value;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stored_ff[i] <= init_digit(i);
         end else if (step && copy && (CNT_W'(i) < cnt_ff)) begin
            stored_ff[i] <= entry_ff[i];
         end
      end
   end

   // decimal display from the four shown digits
   assign display_bin = 14'(shown_in[3]) * 14'd1000 + 14'(shown_in[2]) * 14'd100 +
                        14'(shown_in[1]) * 14'd10 + 14'(shown_in[0]);

   always_comb begin
      result.mode           = mode_in;
      result.bolt_open      = (mode_in == MODE_OPEN);
      result.entered_length = 4'(cnt_in);
      result.display_value  = display_bin;
      result.sound          = sound_in;
      result.wrong_count    = miss_in;
   end

endmodule
`default_nettype wire

>>> design/keypad_combination_lock.sv
`timescale 1ns / 1ps
`default_nettype none
// A request beat is taken into the input register and its result beat is written
// to the result register when that is free; the step logic between the two
// registers is combinational. Throughput: one item per cycle when nothing stalls.
// Reset (synchronous): lock idle, factory code 1234567890 of ten digits, counters
// clear, configuration back to its defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// keypad_combination_lock
// Keypad safe lock: code entry, open and hold-to-lock, programming, alarm and
// master unlock, one result beat per request beat.
// ----------------------------------------------------------------------------
module keypad_combination_lock
   import kcl_pkg::*;
#(
   parameter int MAX_DIGITS = 14
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_payload_type       req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_payload_type            rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic            item_valid;
   req_payload_type item_data;
   logic            advance;
   rsp_payload_type result;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;

   // held item steps when the result register is free
   assign advance = item_valid && (!rsp_valid_ff || !rsp_stall);

   kcl_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   kcl_core #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (advance),
      .item      (item_data),
      .result    (result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // a stepped item always lands in the result register
   a_step_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("stepped item did not produce a result beat");

   // opening clears the wrong-entry count
   a_open_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.sound == SOUND_OPEN)) |->
      ((rsp_data.mode == MODE_OPEN) && (rsp_data.wrong_count == 4'd0)))
      else $error("open sound without open mode or cleared count");

   // siren only sounds in alarm
   a_siren_alarm: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.sound == SOUND_SIREN)) |->
      ((rsp_data.mode == MODE_ALARM) && !rsp_data.bolt_open))
      else $error("siren outside alarm mode");

   // locking returns to idle with the bolt shut
   a_lock_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.sound == SOUND_LOCK)) |->
      ((rsp_data.mode == MODE_IDLE) && !rsp_data.bolt_open))
      else $error("lock sound without idle mode");
`endif

endmodule
`default_nettype wire

>>> verif/kcl_lock_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_lock_checker
// Watches the request, result and register ports of the keypad lock, keeps
// its own copy of the lock state, and compares each result beat, field by
// field, with the oldest predicted result. Mismatches are counted and passed
// to the testbench top.
// ----------------------------------------------------------------------------
module kcl_lock_checker
   import kcl_pkg::*;
#(
   parameter int MAX_DIGITS = 14
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire req_payload_type       req_data,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire rsp_payload_type       rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         fail_count,
   output int                         pending,
   output int                         checked
);

   // register copies
   logic [3:0]  cfg_err_limit;
   logic [15:0] cfg_hold;
   logic [55:0] cfg_master;
   logic [3:0]  cfg_master_len;

   // lock state copy
   logic [2:0]  mode_now;
   logic [3:0]  typed_digits [MAX_DIGITS];
   logic [3:0]  typed_count;
   logic [3:0]  code_digits [MAX_DIGITS];
   logic [3:0]  code_count;
   logic [3:0]  misses;
   logic [15:0] lock_hold;
   logic [15:0] dual_hold;
   logic        dual_armed;
   logic        master_open;
   logic [13:0] shown;

   // predicted results in beat order
   rsp_payload_type lock_results_q [$];

   // keypad position to {is_digit, digit}
   function automatic logic [4:0] key_digit_of(input logic [4:0] key);
      logic [4:0] r;
      case (key)
         5'd1:    r = {1'b1, 4'd1};
         5'd2:    r = {1'b1, 4'd2};
         5'd3:    r = {1'b1, 4'd3};
         5'd5:    r = {1'b1, 4'd4};
         5'd6:    r = {1'b1, 4'd5};
         5'd7:    r = {1'b1, 4'd6};
         5'd9:    r = {1'b1, 4'd7};
         5'd10:   r = {1'b1, 4'd8};
         5'd11:   r = {1'b1, 4'd9};
         5'd14:   r = {1'b1, 4'd0};
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   task automatic reset_lock();
      cfg_err_limit  = ERROR_LIMIT_RESET;
      cfg_hold       = HOLD_TICKS_RESET;
      cfg_master     = MASTER_CODE_RESET;
      cfg_master_len = MASTER_LENGTH_RESET;
      mode_now       = MODE_IDLE;
      typed_count    = 4'd0;
      code_count     = 4'd10;
      misses         = 4'd0;
      lock_hold      = 16'd0;
      dual_hold      = 16'd0;
      dual_armed     = 1'b0;
      master_open    = 1'b0;
      shown          = 14'd0;
      // factory code 1 2 3 4 5 6 7 8 9 0
      for (int i = 0; i < MAX_DIGITS; i++) begin
         typed_digits[i] = 4'd0;
         code_digits[i]  = (i < 9) ? 4'(i + 1) : 4'd0;
      end
   endtask

   function automatic void push_digit(input logic is_digit, input logic [3:0] dig);
      if (is_digit && typed_count < MAX_DIGITS) begin
         typed_digits[typed_count] = dig;
         typed_count = typed_count + 4'd1;
      end
   endfunction

   function automatic bit code_matches();
      bit ok;
      ok = (typed_count == code_count);
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (ok && i < typed_count && typed_digits[i] != code_digits[i]) ok = 1'b0;
      end
      return ok;
   endfunction

   // a length of 0 or 15, or a nibble above nine, can never match
   function automatic bit master_matches();
      bit ok;
      ok = (typed_count == cfg_master_len) && (typed_count <= 14);
      for (int i = 0; i < MAX_DIGITS && i < 14; i++) begin
         if (ok && i < typed_count && typed_digits[i] != cfg_master[4*i +: 4]) ok = 1'b0;
      end
      return ok;
   endfunction

   function automatic void enter_alarm();
      mode_now    = MODE_ALARM;
      typed_count = 4'd0;
      dual_hold   = 16'd0;
      dual_armed  = 1'b0;
      master_open = 1'b0;
   endfunction

   // next lock state and the result beat for one request beat
   function automatic rsp_payload_type step_lock(input req_payload_type r);
      rsp_payload_type o;
      logic [2:0] snd;
      logic [4:0] kd;
      snd = SOUND_NONE;
      kd  = key_digit_of(r.key_code);
      case (r.command)
         CMD_KEY: begin
            if (r.key_code >= KEY_FIRST && r.key_code <= KEY_LAST) begin
               snd = SOUND_KEY;
               // display follows every digit, in any mode
               if (kd[4]) shown = 14'((shown % 14'd1000) * 10 + kd[3:0]);
               case (mode_now)
                  MODE_IDLE: begin
                     if (r.key_code == KEY_HASH) begin
                        mode_now    = MODE_ENTRY;
                        typed_count = 4'd0;
                     end
                  end
                  MODE_ENTRY: begin
                     if (r.key_code != KEY_STAR) begin
                        push_digit(kd[4], kd[3:0]);
                     end else if (typed_count >= MIN_CODE_LEN
                                  && typed_count <= MAX_CODE_LEN) begin
                        if (code_matches()) begin
                           mode_now    = MODE_OPEN;
                           typed_count = 4'd0;
                           misses      = 4'd0;
                           lock_hold   = 16'd0;
                           snd         = SOUND_OPEN;
                        end else begin
                           if (misses < MISS_SAT) misses = misses + 4'd1;
                           if (misses >= cfg_err_limit) begin
                              enter_alarm();
                              snd = SOUND_SIREN;
                           end else begin
                              typed_count = 4'd0;
                              mode_now    = MODE_IDLE;
                              snd         = SOUND_WRONG;
                           end
                        end
                     end
                  end
                  MODE_PROG: push_digit(kd[4], kd[3:0]);
                  MODE_ALARM: begin
                     if (master_open) begin
                        if (r.key_code != KEY_STAR) begin
                           push_digit(kd[4], kd[3:0]);
                        end else if (typed_count != 4'd0) begin
                           dual_armed  = 1'b0;
                           master_open = 1'b0;
                           if (master_matches()) mode_now = MODE_IDLE;
                           else snd = SOUND_SIREN;
                           typed_count = 4'd0;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         CMD_TICK: begin
            if (r.vibration && mode_now != MODE_ALARM) begin
               enter_alarm();
               snd = SOUND_SIREN;
            end
            // star and hash hold in alarm arms the master code
            if (mode_now == MODE_ALARM && r.star_and_hash_held) begin
               if (dual_hold != HOLD_SAT) begin
                  dual_hold = dual_hold + 16'd1;
                  if (dual_hold == cfg_hold) dual_armed = 1'b1;
               end
            end else begin
               dual_hold = 16'd0;
            end
            if (mode_now == MODE_ALARM && dual_armed && !master_open) begin
               master_open = 1'b1;
               typed_count = 4'd0;
               shown       = 14'd0;
            end
            // star hold while open locks again
            if (mode_now == MODE_OPEN && r.star_held) begin
               if (lock_hold != HOLD_SAT) begin
                  lock_hold = lock_hold + 16'd1;
                  if (lock_hold == cfg_hold) begin
                     mode_now  = MODE_IDLE;
                     lock_hold = 16'd0;
                     snd       = SOUND_LOCK;
                  end
               end
            end else begin
               lock_hold = 16'd0;
            end
         end
         CMD_PROG: begin
            if (mode_now != MODE_PROG) begin
               mode_now    = MODE_PROG;
               typed_count = 4'd0;
            end else if (typed_count >= MIN_CODE_LEN && typed_count <= MAX_CODE_LEN) begin
               for (int i = 0; i < MAX_DIGITS; i++) begin
                  if (i < typed_count) code_digits[i] = typed_digits[i];
               end
               code_count  = typed_count;
               typed_count = 4'd0;
               mode_now    = MODE_IDLE;
               snd         = SOUND_SAVED;
            end
         end
         default: ;
      endcase
      o.mode           = mode_now;
      o.bolt_open      = (mode_now == MODE_OPEN);
      o.entered_length = typed_count;
      o.display_value  = shown;
      o.sound          = snd;
      o.wrong_count    = misses;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (fail_count < 30) begin
         $display("[%0t] lock check: %s got %0d, want %0d", $realtime, what, got, want);
      end
      fail_count++;
   endtask

   // register writes, prediction on request beats, compare on result beats
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         reset_lock();
         lock_results_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_ERROR_LIMIT:   cfg_err_limit  = csr_wdata[3:0];
               REG_HOLD_TICKS:    cfg_hold       = csr_wdata[15:0];
               REG_MASTER_CODE:   cfg_master     = csr_wdata[55:0];
               REG_MASTER_LENGTH: cfg_master_len = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) lock_results_q.push_back(step_lock(req_data));
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (lock_results_q.size() == 0) begin
               report_mismatch("result beat with nothing expected", 16'd0, 16'd0);
            end else begin
               want = lock_results_q.pop_front();
               if (rsp_data.mode !== want.mode)
                  report_mismatch("mode", 16'(rsp_data.mode), 16'(want.mode));
               if (rsp_data.bolt_open !== want.bolt_open)
                  report_mismatch("bolt_open", 16'(rsp_data.bolt_open), 16'(want.bolt_open));
               if (rsp_data.entered_length !== want.entered_length)
                  report_mismatch("entered_length", 16'(rsp_data.entered_length),
                                  16'(want.entered_length));
               if (rsp_data.display_value !== want.display_value)
                  report_mismatch("display_value", 16'(rsp_data.display_value),
                                  16'(want.display_value));
               if (rsp_data.sound !== want.sound)
                  report_mismatch("sound", 16'(rsp_data.sound), 16'(want.sound));
               if (rsp_data.wrong_count !== want.wrong_count)
                  report_mismatch("wrong_count", 16'(rsp_data.wrong_count),
                                  16'(want.wrong_count));
            end
         end
      end
      pending = lock_results_q.size();
   end

endmodule

>>> verif/keypad_combination_lock_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_combination_lock_test
// Drives the keypad lock with a short directed opening and then random key,
// tick and program sequences over several register settings and idle
// patterns; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module keypad_combination_lock_test
   import kcl_pkg::*;
;

   localparam int         CYCLE_LIMIT = 400000;
   localparam int         LONG_STALL  = 300;
   localparam int         PHASE_ITEMS = 220;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam logic [4:0] KEY_NONE    = 5'd0;
   localparam logic [4:0] KEY_TOP     = 5'd31;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_payload_type       req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_payload_type       rsp_data;
   logic                  csr_we;
   logic [1:0]            csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int fail_count;
   int pending;
   int checked;

   // stimulus side bookkeeping
   int          send_idle_pct;
   int          recv_idle_pct;
   logic        burst_toggle;
   int          items_sent;
   int          cycle_count;
   logic [15:0] cur_hold;
   logic [55:0] cur_master;
   logic [3:0]  cur_mlen;
   logic [3:0]  shadow_code [14];
   int          shadow_len;

   keypad_combination_lock i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   kcl_lock_checker u_lock_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side stall: random, or a long hold-off when asked
   initial begin
      int   hold_left;
      logic seen;
      rsp_stall <= 1'b0;
      hold_left = 0;
      seen      = 1'b0;
      forever begin
         @(posedge clock);
         if (burst_toggle !== seen) begin
            seen      = burst_toggle;
            hold_left = LONG_STALL;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   function automatic logic [4:0] key_for_digit(input int d);
      logic [4:0] k;
      if (d == 0) k = 5'd14;
      else if (d <= 3) k = 5'(d);
      else if (d <= 6) k = 5'(d + 1);
      else k = 5'(d + 2);
      return k;
   endfunction

   function automatic logic [55:0] random_master(input bit decimal_only);
      logic [55:0] m;
      m = '0;
      for (int i = 0; i < 14; i++) begin
         m[4*i +: 4] = decimal_only ? 4'($urandom_range(0, 9)) : 4'($urandom_range(0, 15));
      end
      return m;
   endfunction

   // one request beat, with random sender gaps; called at a rising edge
   task automatic send_item(input req_payload_type p);
      logic taken;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      items_sent++;
   endtask

   task automatic send_raw(input logic [1:0] cmd, input logic [4:0] key, input logic both,
                           input logic star, input logic vib);
      req_payload_type p;
      p.command            = cmd;
      p.key_code           = key;
      p.star_and_hash_held = both;
      p.star_held          = star;
      p.vibration          = vib;
      send_item(p);
   endtask

   // flags are don't-care on key beats, so they carry random values
   task automatic send_key(input logic [4:0] key);
      send_raw(CMD_KEY, key, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
   endtask

   task automatic send_digit(input int d);
      send_key(key_for_digit(d));
   endtask

   task automatic send_tick(input logic both, input logic star, input logic vib);
      send_raw(CMD_TICK, 5'($urandom_range(0, 31)), both, star, vib);
   endtask

   task automatic send_prog();
      send_raw(CMD_PROG, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   // stop offering and wait until every predicted result has been checked
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_settings(input logic [3:0] limit, input logic [15:0] hold,
                                 input logic [55:0] master, input logic [3:0] mlen);
      csr_we    <= 1'b1;
      csr_index <= REG_ERROR_LIMIT;
      csr_wdata <= CSR_DATA_W'(limit);
      @(posedge clock);
      csr_index <= REG_HOLD_TICKS;
      csr_wdata <= CSR_DATA_W'(hold);
      @(posedge clock);
      csr_index <= REG_MASTER_CODE;
      csr_wdata <= master;
      @(posedge clock);
      csr_index <= REG_MASTER_LENGTH;
      csr_wdata <= CSR_DATA_W'(mlen);
      @(posedge clock);
      csr_we     <= 1'b0;
      cur_hold   = hold;
      cur_master = master;
      cur_mlen   = mlen;
   endtask

   // ticks for a hold: the full hold when short, else a few; sometimes one short
   function automatic int hold_length();
      int k;
      k = (cur_hold <= 16'd16) ? int'(cur_hold) : $urandom_range(1, 6);
      if (k > 1 && $urandom_range(0, 99) < 20) k--;
      return k;
   endfunction

   // hash, the code believed stored, star; spoiled tries miss
   task automatic enter_code(input bit spoil);
      int len;
      int bad_pos;
      int d;
      len     = shadow_len;
      bad_pos = -1;
      if (spoil) begin
         if ($urandom_range(0, 99) < 30) len--;
         else bad_pos = $urandom_range(0, len - 1);
      end
      send_key(KEY_HASH);
      for (int i = 0; i < len; i++) begin
         d = shadow_code[i];
         if (i == bad_pos) d = (d + $urandom_range(1, 9)) % 10;
         send_digit(d);
      end
      send_key(KEY_STAR);
   endtask

   task automatic hold_star();
      int k;
      k = hold_length();
      for (int i = 0; i < k; i++) send_tick(1'($urandom_range(0, 1)), 1'b1, 1'b0);
      send_tick(1'b0, 1'b0, 1'b0);
   endtask

   // program button, a new code of mostly legal length, program button
   task automatic store_code();
      logic [3:0] fresh [16];
      int n;
      n = ($urandom_range(0, 99) < 80) ? $urandom_range(MIN_CODE_LEN, MAX_CODE_LEN)
                                       : $urandom_range(1, 16);
      send_prog();
      for (int i = 0; i < n; i++) begin
         fresh[i] = 4'($urandom_range(0, 9));
         send_digit(fresh[i]);
      end
      send_prog();
      if (n >= MIN_CODE_LEN && n <= MAX_CODE_LEN) begin
         for (int i = 0; i < n; i++) shadow_code[i] = fresh[i];
         shadow_len = n;
      end
   endtask

   // vibration into alarm, star and hash hold, master code, star
   task automatic trip_and_master(input bit spoil);
      int k;
      int n;
      int d;
      send_tick(1'b0, 1'($urandom_range(0, 1)), 1'b1);
      k = hold_length();
      for (int i = 0; i < k; i++) send_tick(1'b1, 1'($urandom_range(0, 1)), 1'b0);
      n = (cur_mlen > 4'd14) ? 14 : int'(cur_mlen);
      for (int i = 0; i < n; i++) begin
         d = cur_master[4*i +: 4];
         if (d > 9) d = $urandom_range(0, 9);
         if (spoil && i == n - 1) d = (d + 1) % 10;
         send_digit(d);
      end
      send_key(KEY_STAR);
   endtask

   task automatic guess_code();
      send_key(KEY_HASH);
      repeat ($urandom_range(MIN_CODE_LEN, MAX_CODE_LEN)) send_digit($urandom_range(0, 9));
      send_key(KEY_STAR);
   endtask

   // anything the fields allow
   task automatic send_noise();
      repeat ($urandom_range(1, 4)) begin
         send_raw(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end
   endtask

   task automatic run_random(input int count, input bit pause_half);
      int start;
      int pick;
      bit paused;
      start  = items_sent;
      paused = 1'b0;
      while (items_sent - start < count) begin
         if (pause_half && !paused && items_sent - start >= count / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            if ($urandom_range(0, 99) < 25) begin
               enter_code(1'b1);
            end else begin
               enter_code(1'b0);
               if ($urandom_range(0, 99) < 60) hold_star();
            end
         end else if (pick < 50) begin
            store_code();
         end else if (pick < 65) begin
            trip_and_master($urandom_range(0, 99) < 20);
         end else if (pick < 75) begin
            guess_code();
         end else begin
            send_noise();
         end
      end
   endtask

   // stimulus and verdict
   initial begin
      req_valid     <= 1'b0;
      req_data      <= '0;
      csr_we        <= 1'b0;
      csr_index     <= REG_ERROR_LIMIT;
      csr_wdata     <= '0;
      reset         <= 1'b1;
      burst_toggle  <= 1'b0;
      recv_idle_pct <= 80;
      send_idle_pct = 7;
      items_sent    = 0;
      cur_hold      = HOLD_TICKS_RESET;
      cur_master    = MASTER_CODE_RESET;
      cur_mlen      = MASTER_LENGTH_RESET;
      for (int i = 0; i < 14; i++) shadow_code[i] = (i < 9) ? 4'(i + 1) : 4'd0;
      shadow_len = 10;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // out-of-range keys, unknown command, plain key, empty star, factory code
      send_key(KEY_NONE);
      send_key(KEY_TOP);
      send_raw(CMD_UNUSED, KEY_HASH, 1'b1, 1'b1, 1'b1);
      send_key(KEY_LAST);
      send_key(KEY_HASH);
      send_key(KEY_STAR);
      for (int d = 1; d <= 10; d++) send_digit(d % 10);
      send_key(KEY_STAR);
      wait_drained();

      // one-tick holds: lock, vibration alarm, master unlock, program out of alarm
      write_settings(4'd1, 16'd1, 56'h19037, 4'd5);
      send_tick(1'b0, 1'b1, 1'b0);
      send_tick(1'b0, 1'b0, 1'b1);
      send_tick(1'b1, 1'b0, 1'b0);
      for (int i = 0; i < 5; i++) send_digit(cur_master[4*i +: 4]);
      send_key(KEY_STAR);
      send_tick(1'b0, 1'b0, 1'b1);
      send_prog();
      send_prog();
      wait_drained();

      // random phases over register settings and idle patterns
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0:       write_settings(4'd15, 16'd65535, random_master(1'b1), 4'd14);
            1:       write_settings(4'd1, 16'd1, random_master(1'b1), 4'd1);
            2:       write_settings(4'd4, 16'd3, random_master(1'b1), 4'd7);
            3:       write_settings(4'd2, 16'd5, random_master(1'b0), 4'd9);
            4:       write_settings(4'd15, 16'd2, random_master(1'b1), 4'd15);
            default: write_settings(4'd3, 16'd4, random_master(1'b1), 4'd12);
         endcase
         if (ph < 2) begin
            send_idle_pct = 7;
            recv_idle_pct <= 80;
         end else if (ph < 4) begin
            send_idle_pct = 80;
            recv_idle_pct <= 7;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end
         // long receiver hold-off while requests keep coming
         if (ph == 1 || ph == 4) burst_toggle <= ~burst_toggle;
         run_random(PHASE_ITEMS, ph == 3);
         wait_drained();
      end

      repeat (4) @(posedge clock);
      $display("run: %0d request beats sent, %0d result beats checked, 7 register settings",
               items_sent, checked);
      $display("run: entry, open and lock, programming, alarm and master unlock, stalls");
      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
